/* rtl/plob_pkg.sv */
`timescale 1ns / 1ps
package plob_pkg;

    localparam int ORD_DEPTH = 4096;
    localparam int ORD_AW    = 12;
    localparam int LVL_DEPTH = 1024;
    localparam int LVL_AW    = 10;
    localparam int SYM_DEPTH = 256;
    localparam int SYM_AW    = 8;

    localparam int IN_DATA_W  = 264;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REDUCE  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_BID     = 3'd4;
    localparam logic [2:0] OP_ASK     = 3'd5;

    localparam logic [3:0] STS_OK          = 4'd0;
    localparam logic [3:0] STS_BAD_ADD     = 4'd1;
    localparam logic [3:0] STS_SYM_FULL    = 4'd2;
    localparam logic [3:0] STS_ORD_FULL    = 4'd3;
    localparam logic [3:0] STS_LVL_FULL    = 4'd4;
    localparam logic [3:0] STS_UNKNOWN     = 4'd5;
    localparam logic [3:0] STS_BAD_REDUCE  = 4'd6;
    localparam logic [3:0] STS_MISMATCH    = 4'd7;
    localparam logic [3:0] STS_BAD_REPLACE = 4'd8;
    localparam logic [3:0] STS_NO_LEVEL    = 4'd9;

    localparam logic [1:0] CFG_ORD_CAP = 2'd0;
    localparam logic [1:0] CFG_LVL_CAP = 2'd1;
    localparam logic [1:0] CFG_SYM_CAP = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [63:0] sym;
        logic        side;
        logic [31:0] price;
        logic [31:0] rem;
    } t_order;

    typedef struct packed {
        logic        valid;
        logic [63:0] sym;
        logic        side;
        logic [31:0] price;
        logic [63:0] total;
        logic [12:0] cnt;
    } t_level;

endpackage

/* rtl/plob_ram.sv */
`timescale 1ns / 1ps
module plob_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/price_level_order_book_core.sv */
// An update makes one full sweep of the order table (4096 entries) and, as needed,
// a sweep of the symbol entries in use and of the level table (1024 entries), followed
// by checks; a replace sweeps the level table twice. Queries sweep the level table only.
// One word is handled at a time; the next word is taken as soon as the result is registered.
// Reset is synchronous and active low; afterwards a clearing pass over the 4096 order entries
// empties the order and level tables before the first word is accepted.
`timescale 1ns / 1ps
module price_level_order_book_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // order reference, new order reference, symbol, side, price, shares
    input  logic [plob_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // operation
    input  logic [plob_pkg::IN_USER_W-1:0]       i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // status, level_price, level_shares, level_orders, live_orders, known_symbols
    output logic [plob_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [plob_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [plob_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import plob_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_OSCAN = 4'd2;
    localparam logic [3:0] S_OCHK  = 4'd3;
    localparam logic [3:0] S_SSCAN = 4'd4;
    localparam logic [3:0] S_ACHK  = 4'd5;
    localparam logic [3:0] S_LSCAN = 4'd6;
    localparam logic [3:0] S_LCHK  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  r_state;
    logic [12:0] r_scnt;
    logic        r_pv;
    logic [11:0] r_pidx;

    logic [12:0] r_cap_o;
    logic [10:0] r_cap_l;
    logic [8:0]  r_cap_s;
    logic [12:0] r_ocnt;
    logic [10:0] r_lcnt;
    logic [8:0]  r_sym_cnt;

    logic [2:0]  r_op;
    logic [63:0] r_id;
    logic [63:0] r_nid;
    logic [31:0] r_shares;
    logic [31:0] r_nprice;
    logic [63:0] r_ksym;
    logic        r_kside;
    logic [31:0] r_kprice;
    logic        r_adding;
    logic [31:0] r_amt;

    logic        r_fa;
    logic        r_fb;
    logic [11:0] r_oi;
    t_order      r_od;
    logic        r_ofree_ok;
    logic [11:0] r_ofree;
    logic        r_known;
    logic        r_lf;
    logic [9:0]  r_li;
    logic [63:0] r_ltot;
    logic [12:0] r_lent;
    logic        r_lfree_ok;
    logic [9:0]  r_lfree;
    logic        r_bf;
    logic [31:0] r_bprice;
    logic [63:0] r_btot;
    logic [12:0] r_bcnt;

    logic [3:0]  r_status;
    logic        r_mv;
    logic [OUT_DATA_W-1:0] r_mdata;

    logic                 ord_we;
    logic [ORD_AW-1:0]    ord_waddr;
    t_order               ord_wdata;
    logic [$bits(t_order)-1:0] ord_rd;
    t_order               ord_q;
    logic                 lvl_we;
    logic [LVL_AW-1:0]    lvl_waddr;
    t_level               lvl_wdata;
    logic [$bits(t_level)-1:0] lvl_rd;
    t_level               lvl_q;
    logic                 sym_we;
    logic [63:0]          sym_q;

    logic [12:0] cap_o_eff;
    logic [10:0] cap_l_eff;
    logic [8:0]  cap_s_eff;
    logic [12:0] scan_len;
    logic        scan_st;
    logic        issue;
    logic        scan_end;
    logic        is_query;
    logic        want;
    logic        lq_hit;
    logic        cand;
    logic        better;
    logic [63:0] newtot;
    logic [31:0] newrem;
    logic        gone;
    logic [12:0] cnt1;
    logic        add_fail;
    logic        take_fail;

    plob_ram #(.W($bits(t_order)), .D(ORD_DEPTH)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(r_scnt[ORD_AW-1:0]), .o_rdata(ord_rd)
    );
    plob_ram #(.W($bits(t_level)), .D(LVL_DEPTH)) u_lvl (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_raddr(r_scnt[LVL_AW-1:0]), .o_rdata(lvl_rd)
    );
    plob_ram #(.W(64), .D(SYM_DEPTH)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(r_sym_cnt[SYM_AW-1:0]), .i_wdata(r_ksym),
        .i_raddr(r_scnt[SYM_AW-1:0]), .o_rdata(sym_q)
    );

    assign ord_q = t_order'(ord_rd);
    assign lvl_q = t_level'(lvl_rd);

    assign cap_o_eff = (r_cap_o > 13'(ORD_DEPTH)) ? 13'(ORD_DEPTH) : r_cap_o;
    assign cap_l_eff = (r_cap_l > 11'(LVL_DEPTH)) ? 11'(LVL_DEPTH) : r_cap_l;
    assign cap_s_eff = (r_cap_s > 9'(SYM_DEPTH)) ? 9'(SYM_DEPTH) : r_cap_s;

    always_comb begin
        unique case (r_state)
            S_OSCAN: scan_len = 13'(ORD_DEPTH);
            S_LSCAN: scan_len = 13'(LVL_DEPTH);
            S_SSCAN: scan_len = 13'(r_sym_cnt);
            default: scan_len = '0;
        endcase
    end

    assign scan_st  = (r_state == S_OSCAN) || (r_state == S_LSCAN) || (r_state == S_SSCAN);
    assign issue    = scan_st && (r_scnt < scan_len);
    assign scan_end = scan_st && (r_scnt == scan_len) && !r_pv;
    assign is_query = (r_op == OP_BID) || (r_op == OP_ASK);
    assign want     = (r_op == OP_ASK);

    assign lq_hit = lvl_q.valid && (lvl_q.sym == r_ksym) && (lvl_q.side == r_kside)
                    && (lvl_q.price == r_kprice);
    assign cand   = lvl_q.valid && (lvl_q.sym == r_ksym) && (lvl_q.side == want);
    assign better = !r_bf || (want ? (lvl_q.price < r_bprice) : (lvl_q.price > r_bprice));

    assign newtot    = r_ltot - 64'(r_amt);
    assign newrem    = r_od.rem - r_amt;
    assign gone      = (newrem == 32'd0);
    assign cnt1      = (gone && r_lent != 13'd0) ? r_lent - 13'd1 : r_lent;
    assign add_fail  = !r_lf && (r_lcnt >= cap_l_eff);
    assign take_fail = !r_lf || (r_ltot < 64'(r_amt));

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_scnt[ORD_AW-1:0];
        ord_wdata = '0;
        lvl_we    = 1'b0;
        lvl_waddr = r_scnt[LVL_AW-1:0];
        lvl_wdata = '0;
        sym_we    = 1'b0;
        if (r_state == S_CLEAR) begin
            ord_we = 1'b1;
            lvl_we = (r_scnt[ORD_AW-1:LVL_AW] == '0);
        end else if (r_state == S_LCHK && !is_query) begin
            if (r_adding) begin
                if (!add_fail) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_ofree;
                    ord_wdata = '{valid: 1'b1, key: r_id, sym: r_ksym, side: r_kside,
                                  price: r_kprice, rem: r_shares};
                    lvl_we    = 1'b1;
                    lvl_waddr = r_lf ? r_li : r_lfree;
                    lvl_wdata = '{valid: 1'b1, sym: r_ksym, side: r_kside, price: r_kprice,
                                  total: (r_lf ? r_ltot : 64'd0) + 64'(r_shares),
                                  cnt: (r_lf ? r_lent : 13'd0) + 13'd1};
                    sym_we    = !r_known;
                end
            end else if (!take_fail) begin
                ord_we    = 1'b1;
                ord_waddr = r_oi;
                ord_wdata = r_od;
                ord_wdata.valid = !gone;
                ord_wdata.rem   = newrem;
                lvl_we    = 1'b1;
                lvl_waddr = r_li;
                lvl_wdata = '{valid: (cnt1 != 13'd0), sym: r_ksym, side: r_kside,
                              price: r_kprice, total: newtot, cnt: cnt1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_scnt    <= '0;
            r_pv      <= 1'b0;
            r_cap_o   <= 13'(ORD_DEPTH);
            r_cap_l   <= 11'(LVL_DEPTH);
            r_cap_s   <= 9'(SYM_DEPTH);
            r_ocnt    <= '0;
            r_lcnt    <= '0;
            r_sym_cnt <= '0;
            r_mv      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORD_CAP: r_cap_o <= i_cfg_data;
                    CFG_LVL_CAP: r_cap_l <= i_cfg_data[10:0];
                    CFG_SYM_CAP: r_cap_s <= i_cfg_data[8:0];
                    default: ;
                endcase
            end

            if (r_mv && i_m_tready && (r_state != S_DONE)) begin
                r_mv <= 1'b0;
            end

            r_pv   <= issue;
            r_pidx <= r_scnt[11:0];
            if (issue) begin
                r_scnt <= r_scnt + 13'd1;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_scnt[ORD_AW-1:0] == '1) begin
                        r_scnt  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_scnt <= r_scnt + 13'd1;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op       <= i_s_tuser;
                        r_id       <= i_s_tdata[63:0];
                        r_nid      <= i_s_tdata[127:64];
                        r_ksym     <= i_s_tdata[191:128];
                        r_kside    <= i_s_tdata[192];
                        r_kprice   <= i_s_tdata[224:193];
                        r_nprice   <= i_s_tdata[224:193];
                        r_shares   <= i_s_tdata[256:225];
                        r_adding   <= (i_s_tuser == OP_ADD);
                        r_status   <= STS_OK;
                        r_fa       <= 1'b0;
                        r_fb       <= 1'b0;
                        r_ofree_ok <= 1'b0;
                        r_known    <= 1'b0;
                        r_lf       <= 1'b0;
                        r_lfree_ok <= 1'b0;
                        r_bf       <= 1'b0;
                        r_bprice   <= '0;
                        r_btot     <= '0;
                        r_bcnt     <= '0;
                        r_scnt     <= '0;
                        if (i_s_tuser == OP_BID || i_s_tuser == OP_ASK) begin
                            r_state <= S_LSCAN;
                        end else if (i_s_tuser <= OP_REPLACE) begin
                            r_state <= S_OSCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_OSCAN: begin
                    if (r_pv) begin
                        if (ord_q.valid && ord_q.key == r_id) begin
                            r_fa <= 1'b1;
                            r_oi <= r_pidx;
                            r_od <= ord_q;
                        end
                        if (ord_q.valid && ord_q.key == r_nid) begin
                            r_fb <= 1'b1;
                        end
                        if (!ord_q.valid && !r_ofree_ok) begin
                            r_ofree_ok <= 1'b1;
                            r_ofree    <= r_pidx;
                        end
                    end
                    if (scan_end) begin
                        r_state <= S_OCHK;
                    end
                end
                S_OCHK: begin
                    r_scnt <= '0;
                    if (r_op == OP_ADD) begin
                        if (r_shares == 32'd0 || r_fa) begin
                            r_status <= STS_BAD_ADD;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SSCAN;
                        end
                    end else if (r_op == OP_REPLACE) begin
                        if (!r_fa || r_fb) begin
                            r_status <= STS_BAD_REPLACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_amt    <= r_od.rem;
                            r_ksym   <= r_od.sym;
                            r_kside  <= r_od.side;
                            r_kprice <= r_od.price;
                            r_state  <= S_LSCAN;
                        end
                    end else if (!r_fa) begin
                        r_status <= STS_UNKNOWN;
                        r_state  <= S_DONE;
                    end else if (r_op == OP_REDUCE &&
                                 (r_shares == 32'd0 || r_shares > r_od.rem)) begin
                        r_status <= STS_BAD_REDUCE;
                        r_state  <= S_DONE;
                    end else begin
                        r_amt    <= (r_op == OP_DELETE) ? r_od.rem : r_shares;
                        r_ksym   <= r_od.sym;
                        r_kside  <= r_od.side;
                        r_kprice <= r_od.price;
                        r_state  <= S_LSCAN;
                    end
                end
                S_SSCAN: begin
                    if (r_pv && sym_q == r_ksym) begin
                        r_known <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_ACHK;
                    end
                end
                S_ACHK: begin
                    r_scnt <= '0;
                    if (!r_known && r_sym_cnt >= cap_s_eff) begin
                        r_status <= STS_SYM_FULL;
                        r_state  <= S_DONE;
                    end else if (r_ocnt >= cap_o_eff) begin
                        r_status <= STS_ORD_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_lf       <= 1'b0;
                        r_lfree_ok <= 1'b0;
                        r_state    <= S_LSCAN;
                    end
                end
                S_LSCAN: begin
                    if (r_pv) begin
                        if (lq_hit && !r_lf) begin
                            r_lf   <= 1'b1;
                            r_li   <= r_pidx[LVL_AW-1:0];
                            r_ltot <= lvl_q.total;
                            r_lent <= lvl_q.cnt;
                        end
                        if (!lvl_q.valid && !r_lfree_ok) begin
                            r_lfree_ok <= 1'b1;
                            r_lfree    <= r_pidx[LVL_AW-1:0];
                        end
                        if (is_query && cand && better) begin
                            r_bf     <= 1'b1;
                            r_bprice <= lvl_q.price;
                            r_btot   <= lvl_q.total;
                            r_bcnt   <= lvl_q.cnt;
                        end
                    end
                    if (scan_end) begin
                        r_state <= S_LCHK;
                    end
                end
                S_LCHK: begin
                    r_scnt <= '0;
                    if (is_query) begin
                        r_state <= S_DONE;
                        if (!r_bf) begin
                            r_status <= STS_NO_LEVEL;
                        end
                    end else if (r_adding) begin
                        r_state <= S_DONE;
                        if (add_fail) begin
                            r_status <= STS_LVL_FULL;
                        end else begin
                            r_ocnt <= r_ocnt + 13'd1;
                            if (!r_lf) begin
                                r_lcnt <= r_lcnt + 11'd1;
                            end
                            if (!r_known) begin
                                r_sym_cnt <= r_sym_cnt + 9'd1;
                            end
                        end
                    end else if (take_fail) begin
                        r_status <= STS_MISMATCH;
                        r_state  <= S_DONE;
                    end else begin
                        if (gone) begin
                            r_ocnt <= r_ocnt - 13'd1;
                        end
                        if (cnt1 == 13'd0) begin
                            r_lcnt <= r_lcnt - 11'd1;
                        end
                        if (r_op == OP_REPLACE) begin
                            r_adding   <= 1'b1;
                            r_id       <= r_nid;
                            r_kprice   <= r_nprice;
                            r_ofree    <= r_oi;
                            r_known    <= 1'b0;
                            r_lf       <= 1'b0;
                            r_lfree_ok <= 1'b0;
                            if (r_shares == 32'd0) begin
                                r_status <= STS_BAD_ADD;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_SSCAN;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_mv || i_m_tready) begin
                        r_mv    <= 1'b1;
                        r_mdata <= {1'b0, r_sym_cnt, r_ocnt, r_bcnt, r_btot, r_bprice, r_status};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_mdata;

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt <= 13'(ORD_DEPTH)) && (r_lcnt <= 11'(LVL_DEPTH))
        && (r_sym_cnt <= 9'(SYM_DEPTH)))
        else $error("table count beyond its size");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_m_tvalid && r_ocnt == 13'd0))
        else $error("result or live order during clearing pass");
endmodule
